// ===== src/cbsp_pkg.sv =====
`timescale 1ns / 1ps

package cbsp_pkg;

   // Default depth of the sysex buffer in bytes.
   localparam int BUFFER_BYTES_DEF = 64;

   // Depth of the operation queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Protocol codes.
   localparam logic [7:0] CODE_ANALOG      = 8'hE0;
   localparam logic [7:0] CODE_DIGITAL     = 8'h90;
   localparam logic [7:0] CODE_REPANALOG   = 8'hC0;
   localparam logic [7:0] CODE_REPDIGITAL  = 8'hD0;
   localparam logic [7:0] CODE_PINMODE     = 8'hF4;
   localparam logic [7:0] CODE_SYSEX_START = 8'hF0;
   localparam logic [7:0] CODE_SYSEX_END   = 8'hF7;
   localparam logic [7:0] CODE_VERSION     = 8'hF9;
   localparam logic [7:0] CODE_RESET       = 8'hFF;
   localparam logic [7:0] SYSEX_STRING     = 8'h71;
   localparam logic [7:0] SYSEX_FIRMWARE   = 8'h79;

   // Bit positions in the event enable register.
   localparam int EN_ANALOG     = 0;
   localparam int EN_DIGITAL    = 1;
   localparam int EN_PINMODE    = 2;
   localparam int EN_REPANALOG  = 3;
   localparam int EN_REPDIGITAL = 4;
   localparam int EN_STRING     = 5;
   localparam int EN_SYSEX      = 6;
   localparam int EN_RESET      = 7;

   typedef enum logic [3:0] {
      KIND_ANALOG     = 4'd0,
      KIND_DIGITAL    = 4'd1,
      KIND_PINMODE    = 4'd2,
      KIND_REPANALOG  = 4'd3,
      KIND_REPDIGITAL = 4'd4,
      KIND_SYSEXBYTE  = 4'd5,
      KIND_STRINGCHAR = 4'd6,
      KIND_FWREQ      = 4'd7,
      KIND_VERSIONREQ = 4'd8,
      KIND_RESET      = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      PEND_NONE,
      PEND_ANALOG,
      PEND_DIGITAL,
      PEND_PINMODE,
      PEND_REPANALOG,
      PEND_REPDIGITAL
   } pend_type;

   typedef enum logic [1:0] {
      OP_EMIT,
      OP_START,
      OP_STORE,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD,
      ST_RAW,
      ST_LO,
      ST_HI,
      ST_ZERO
   } back_state_type;

   typedef struct packed {
      op_type      op;
      kind_type    kind;
      logic [6:0]  target;
      logic [13:0] value;
   } op_entry_type;

   typedef struct packed {
      kind_type    kind;
      logic [6:0]  target;
      logic [13:0] value;
      logic [7:0]  sysex_command;
      logic [5:0]  sysex_length;
      logic        overflow;
      logic        last;
   } result_type;

endpackage

// ===== src/cbsp_front.sv =====
`timescale 1ns / 1ps

module cbsp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            event_enable,
   output logic                  push,
   output cbsp_pkg::op_entry_type push_entry
);
   import cbsp_pkg::*;

   logic       in_sysex_ff, in_sysex_in;
   logic [1:0] wait_ff, wait_in;
   pend_type   pend_ff, pend_in;
   logic [3:0] chan_ff, chan_in;
   logic [6:0] first_ff, first_in;
   logic       op_valid;
   logic [7:0] code;

   // Status bytes below the system range carry a channel in the low nibble.
   assign code = (rx_byte < CODE_SYSEX_START) ? {rx_byte[7:4], 4'h0} : rx_byte;

   always_comb begin
      in_sysex_in = in_sysex_ff;
      wait_in     = wait_ff;
      pend_in     = pend_ff;
      chan_in     = chan_ff;
      first_in    = first_ff;
      op_valid    = 1'b0;
      push_entry        = '0;
      push_entry.op     = OP_EMIT;
      push_entry.kind   = KIND_ANALOG;

      if (in_sysex_ff) begin
         op_valid = 1'b1;
         if (rx_byte == CODE_SYSEX_END) begin
            push_entry.op = OP_FINISH;
            in_sysex_in   = 1'b0;
         end else begin
            push_entry.op    = OP_STORE;
            push_entry.value = 14'(rx_byte);
         end
      end else if (wait_ff != 2'd0 && !rx_byte[7]) begin
         wait_in = wait_ff - 2'd1;
         if (wait_ff == 2'd2) begin
            first_in = rx_byte[6:0];
         end else if (pend_ff != PEND_NONE) begin
            pend_in = PEND_NONE;
            case (pend_ff)
               PEND_ANALOG: begin
                  op_valid          = event_enable[EN_ANALOG];
                  push_entry.kind   = KIND_ANALOG;
                  push_entry.target = {3'b000, chan_ff};
                  push_entry.value  = {rx_byte[6:0], first_ff};
               end
               PEND_DIGITAL: begin
                  op_valid          = event_enable[EN_DIGITAL];
                  push_entry.kind   = KIND_DIGITAL;
                  push_entry.target = {3'b000, chan_ff};
                  push_entry.value  = {rx_byte[6:0], first_ff};
               end
               PEND_PINMODE: begin
                  op_valid          = event_enable[EN_PINMODE];
                  push_entry.kind   = KIND_PINMODE;
                  push_entry.target = first_ff;
                  push_entry.value  = 14'(rx_byte[6:0]);
               end
               PEND_REPANALOG: begin
                  op_valid          = event_enable[EN_REPANALOG];
                  push_entry.kind   = KIND_REPANALOG;
                  push_entry.target = first_ff;
                  push_entry.value  = 14'(rx_byte[6:0]);
               end
               PEND_REPDIGITAL: begin
                  op_valid          = event_enable[EN_REPDIGITAL];
                  push_entry.kind   = KIND_REPDIGITAL;
                  push_entry.target = {3'b000, chan_ff};
                  push_entry.value  = 14'(rx_byte[6:0]);
               end
               default: begin
                  op_valid = 1'b0;
               end
            endcase
         end
      end else begin
         if (rx_byte < CODE_SYSEX_START) begin
            chan_in = rx_byte[3:0];
         end
         case (code)
            CODE_ANALOG: begin
               wait_in = 2'd2;
               pend_in = PEND_ANALOG;
            end
            CODE_DIGITAL: begin
               wait_in = 2'd2;
               pend_in = PEND_DIGITAL;
            end
            CODE_PINMODE: begin
               wait_in = 2'd2;
               pend_in = PEND_PINMODE;
            end
            CODE_REPANALOG: begin
               wait_in = 2'd2;
               pend_in = PEND_REPANALOG;
            end
            CODE_REPDIGITAL: begin
               wait_in = 2'd1;
               pend_in = PEND_REPDIGITAL;
            end
            CODE_SYSEX_START: begin
               in_sysex_in   = 1'b1;
               op_valid      = 1'b1;
               push_entry.op = OP_START;
            end
            CODE_RESET: begin
               in_sysex_in     = 1'b0;
               wait_in         = 2'd0;
               pend_in         = PEND_NONE;
               chan_in         = 4'd0;
               first_in        = 7'd0;
               op_valid        = event_enable[EN_RESET];
               push_entry.kind = KIND_RESET;
            end
            CODE_VERSION: begin
               op_valid        = 1'b1;
               push_entry.kind = KIND_VERSIONREQ;
            end
            default: begin
               op_valid = 1'b0;
            end
         endcase
      end
   end

   assign push = accept && op_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sysex_ff <= 1'b0;
         wait_ff     <= 2'd0;
         pend_ff     <= PEND_NONE;
         chan_ff     <= 4'd0;
         first_ff    <= 7'd0;
      end else if (accept) begin
         in_sysex_ff <= in_sysex_in;
         wait_ff     <= wait_in;
         pend_ff     <= pend_in;
         chan_ff     <= chan_in;
         first_ff    <= first_in;
      end
   end

endmodule

// ===== src/cbsp_queue.sv =====
`timescale 1ns / 1ps

module cbsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cbsp_pkg::op_entry_type push_entry,
   input  logic                   pop,
   output cbsp_pkg::op_entry_type head,
   output logic                   empty,
   output logic                   full
);
   import cbsp_pkg::*;

   op_entry_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/cbsp_back.sv =====
`timescale 1ns / 1ps

module cbsp_back #(
   parameter int BUFFER_BYTES = cbsp_pkg::BUFFER_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cbsp_pkg::op_entry_type head,
   input  logic                   empty,
   output logic                   pop,
   input  logic [7:0]             event_enable,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output cbsp_pkg::result_type   rsp
);
   import cbsp_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = $clog2(BUFFER_BYTES + 1);

   logic [7:0]     mem [BUFFER_BYTES];
   logic [7:0]     rd_data_ff;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;

   back_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [7:0]     lo_ff, lo_in;
   logic [7:0]     cmd_ff, cmd_in;
   logic           rsp_valid_ff;
   result_type     rsp_ff, rsp_in;
   logic           emit;

   logic           out_free;
   logic           is_fw, is_str;
   logic [CW-1:0]  len;
   logic [5:0]     len6;
   logic           len_zero, chars_zero;
   logic [7:0]     char_val;
   logic           raw_last, hi_last;
   logic [AW-1:0]  idx_next;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_fw      = (rd_data_ff == SYSEX_FIRMWARE);
   assign is_str     = (rd_data_ff == SYSEX_STRING);
   assign len        = count_ff - CW'(1);
   assign len6       = 6'(len);
   assign len_zero   = (count_ff == CW'(1));
   assign chars_zero = (count_ff < CW'(3));
   // Character is the low byte of lsb + (msb << 7).
   assign char_val   = lo_ff + {rd_data_ff[0], 7'b0000000};
   assign raw_last   = (CW'(idx_ff) == len);
   assign hi_last    = (CW'(idx_ff) == {len[CW-1:1], 1'b0});
   assign idx_next   = idx_ff + AW'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!empty && head.op == OP_FINISH && count_ff != '0) begin
               state_in = ST_CMD;
            end
         end
         ST_CMD: begin
            if (is_fw) begin
               if (out_free) state_in = ST_IDLE;
            end else if (is_str) begin
               if (!event_enable[EN_STRING]) begin
                  state_in = ST_IDLE;
               end else if (chars_zero) begin
                  if (out_free) state_in = ST_IDLE;
               end else begin
                  state_in = ST_LO;
               end
            end else if (event_enable[EN_SYSEX]) begin
               if (len_zero) begin
                  if (out_free) state_in = ST_IDLE;
               end else begin
                  state_in = ST_RAW;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RAW: begin
            if (out_free && raw_last) state_in = ST_IDLE;
         end
         ST_LO: begin
            state_in = ST_HI;
         end
         ST_HI: begin
            if (out_free) begin
               if (char_val == 8'd0) begin
                  state_in = ST_IDLE;
               end else if (hi_last) begin
                  state_in = ST_ZERO;
               end else begin
                  state_in = ST_LO;
               end
            end
         end
         ST_ZERO: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      pop      = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      emit     = 1'b0;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      lo_in    = lo_ff;
      cmd_in   = cmd_ff;
      rsp_in               = '0;
      rsp_in.kind          = KIND_SYSEXBYTE;
      rsp_in.sysex_command = cmd_ff;
      rsp_in.sysex_length  = len6;
      rsp_in.overflow      = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               case (head.op)
                  OP_EMIT: begin
                     if (out_free) begin
                        pop                  = 1'b1;
                        emit                 = 1'b1;
                        rsp_in               = '0;
                        rsp_in.kind          = head.kind;
                        rsp_in.target        = head.target;
                        rsp_in.value         = head.value;
                        rsp_in.last          = 1'b1;
                     end
                  end
                  OP_START: begin
                     pop      = 1'b1;
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  OP_STORE: begin
                     pop = 1'b1;
                     if (count_ff < CW'(BUFFER_BYTES)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_FINISH: begin
                     pop = 1'b1;
                     if (count_ff != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_CMD: begin
            cmd_in               = rd_data_ff;
            rsp_in.sysex_command = rd_data_ff;
            rsp_in.last          = 1'b1;
            if (is_fw) begin
               rsp_in.kind = KIND_FWREQ;
               emit        = out_free;
            end else if (is_str) begin
               rsp_in.kind = KIND_STRINGCHAR;
               if (event_enable[EN_STRING]) begin
                  if (chars_zero) begin
                     emit = out_free;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(1);
                     idx_in  = AW'(1);
                  end
               end
            end else if (event_enable[EN_SYSEX]) begin
               if (len_zero) begin
                  emit = out_free;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(1);
                  idx_in  = AW'(1);
               end
            end
         end
         ST_RAW: begin
            rsp_in.value = 14'(rd_data_ff);
            rsp_in.last  = raw_last;
            if (out_free) begin
               emit = 1'b1;
               if (!raw_last) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_next;
                  idx_in  = idx_next;
               end
            end
         end
         ST_LO: begin
            lo_in   = rd_data_ff;
            rd_en   = 1'b1;
            rd_addr = idx_next;
            idx_in  = idx_next;
         end
         ST_HI: begin
            rsp_in.kind  = KIND_STRINGCHAR;
            rsp_in.value = 14'(char_val);
            rsp_in.last  = (char_val == 8'd0);
            if (out_free) begin
               emit = 1'b1;
               if (char_val != 8'd0 && !hi_last) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_next;
                  idx_in  = idx_next;
               end
            end
         end
         ST_ZERO: begin
            rsp_in.kind = KIND_STRINGCHAR;
            rsp_in.last = 1'b1;
            emit        = out_free;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      lo_ff  <= lo_in;
      cmd_ff <= cmd_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= head.value[7:0];
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== src/control_byte_stream_parser.sv =====
// A byte that completes a command reaches the output through the operation queue and the
// output register; a sysex end byte first reads the command byte from the buffer.
// The front end takes one byte per cycle into a four-word queue while the queue is not
// full; a sysex flush holds the back end while it sends each raw byte, or each string
// character (two buffer bytes each) and an appended zero (one buffer read port).
// Reset is synchronous and active high: parser state, queue and output clear, the event
// enable register returns to all ones; the sysex buffer needs no clearing pass.
`timescale 1ns / 1ps

module control_byte_stream_parser #(
   parameter int BUFFER_BYTES = cbsp_pkg::BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Received byte word.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // Result word.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [6:0]  rsp_target,
   output logic [13:0] rsp_value,
   output logic [7:0]  rsp_sysex_command,
   output logic [5:0]  rsp_sysex_length,
   output logic        rsp_overflow,
   output logic        rsp_last,
   // Event enable register write word.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_event_enable
);
   import cbsp_pkg::*;

   logic         csr_write;
   logic [7:0]   enable_ff;
   logic         accept;
   logic         q_push, q_pop, q_empty, q_full;
   op_entry_type q_push_entry, q_head;
   result_type   rsp;

   // The enable register is always writable; the user must change it only while the parser
   // is quiet (the block does not enforce this), so both halves can read it directly.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 8'hFF;
      end else if (csr_write) begin
         enable_ff <= csr_event_enable;
      end
   end

   // The front end takes a byte whenever the queue has a free slot. Every byte
   // updates the parser state; at most one operation per byte enters the queue.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   cbsp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .event_enable (enable_ff),
      .push         (q_push),
      .push_entry   (q_push_entry)
   );

   // The queue lets the front keep taking bytes while the back end walks
   // the sysex buffer or waits on a stalled result.
   cbsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // The back end owns the sysex buffer and the output register. It carries
   // out operations in order, so buffer writes for a new message never pass
   // the flush of the previous one.
   cbsp_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .empty        (q_empty),
      .pop          (q_pop),
      .event_enable (enable_ff),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp)
   );

   assign rsp_kind          = rsp.kind;
   assign rsp_target        = rsp.target;
   assign rsp_value         = rsp.value;
   assign rsp_sysex_command = rsp.sysex_command;
   assign rsp_sysex_length  = rsp.sysex_length;
   assign rsp_overflow      = rsp.overflow;
   assign rsp_last          = rsp.last;

   // Results that are not sysex output stand alone and are always the last word.
   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ANALOG || rsp_kind == KIND_DIGITAL ||
      rsp_kind == KIND_PINMODE || rsp_kind == KIND_REPANALOG ||
      rsp_kind == KIND_REPDIGITAL || rsp_kind == KIND_VERSIONREQ ||
      rsp_kind == KIND_RESET || rsp_kind == KIND_FWREQ) |-> rsp_last)
      else $error("single result word without last");

   // Sysex fields stay zero on results that do not come from a sysex message.
   a_no_sysex_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ANALOG || rsp_kind == KIND_DIGITAL ||
      rsp_kind == KIND_PINMODE || rsp_kind == KIND_REPANALOG ||
      rsp_kind == KIND_REPDIGITAL || rsp_kind == KIND_VERSIONREQ ||
      rsp_kind == KIND_RESET) |->
      (rsp_sysex_command == 8'd0 && rsp_sysex_length == 6'd0 && !rsp_overflow))
      else $error("sysex fields set on a plain result");

   // A zero character terminates the string.
   a_zero_char_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STRINGCHAR && rsp_value == 14'd0 |-> rsp_last)
      else $error("string terminator not marked last");

endmodule
